[rtl/urtb_pkg.sv]
package urtb_pkg;

	localparam int RX_DEPTH = 64;
	localparam int TX_DEPTH = 64;
	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam int FREE_W = 7;

	typedef enum logic [1:0] {
		REQ_LINE_RX = 2'd0,
		REQ_HOST_GET = 2'd1,
		REQ_HOST_PUT = 2'd2,
		REQ_TX_DONE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_TX_FULL = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic execute;
	} cmd_t;

	function automatic logic [RX_AW-1:0] rx_wrap(input logic [RX_AW-1:0] p);
		return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [TX_AW-1:0] tx_wrap(input logic [TX_AW-1:0] p);
		return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

[rtl/urtb_ctrl.sv]
module urtb_ctrl import urtb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.execute = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

endmodule

[rtl/urtb_dp.sv]
module urtb_dp import urtb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic [1:0]        req_type,
	input  logic [7:0]        data_byte,
	output logic [7:0]        line_byte,
	output logic              line_valid,
	output logic [7:0]        host_byte,
	output logic              host_valid,
	output logic [1:0]        status,
	output logic [FREE_W-1:0] tx_free
);

	logic [7:0] rx_mem [RX_DEPTH];
	logic [7:0] tx_mem [TX_DEPTH];

	req_t       req_s1;
	logic [7:0] data_s1;
	logic [7:0] rx_rd_q, tx_rd_q;

	logic [RX_AW-1:0] rx_wp_q, rx_rp_q, rx_wp_d, rx_rp_d;
	logic [TX_AW-1:0] tx_wp_q, tx_rp_q, tx_wp_d, tx_rp_d;
	logic             tx_busy_q, tx_busy_d;

	logic rx_we, tx_we;
	logic [7:0] line_byte_d, host_byte_d;
	logic line_valid_d, host_valid_d;
	status_t status_d;
	logic [TX_AW:0] tx_cnt, tx_room;

	logic [7:0] line_byte_q, host_byte_q;
	logic line_valid_q, host_valid_q;
	status_t status_q;
	logic [FREE_W-1:0] tx_free_q;

	always_comb begin
		rx_wp_d = rx_wp_q;
		rx_rp_d = rx_rp_q;
		tx_wp_d = tx_wp_q;
		tx_rp_d = tx_rp_q;
		tx_busy_d = tx_busy_q;
		rx_we = 1'b0;
		tx_we = 1'b0;
		line_byte_d = '0;
		line_valid_d = 1'b0;
		host_byte_d = '0;
		host_valid_d = 1'b0;
		status_d = ST_OK;
		case (req_s1)
			REQ_LINE_RX: begin
				// A full ring keeps overwriting its last free slot.
				rx_we = 1'b1;
				if (rx_wrap(rx_wp_q) != rx_rp_q) begin
					rx_wp_d = rx_wrap(rx_wp_q);
				end else begin
					status_d = ST_OVERFLOW;
				end
			end
			REQ_HOST_GET: begin
				if (rx_wp_q == rx_rp_q) begin
					status_d = ST_EMPTY;
				end else begin
					host_byte_d = rx_rd_q;
					host_valid_d = 1'b1;
					rx_rp_d = rx_wrap(rx_rp_q);
				end
			end
			REQ_HOST_PUT: begin
				if (!tx_busy_q) begin
					if (tx_wp_q == tx_rp_q) begin
						line_byte_d = data_s1;
					end else begin
						// Queued bytes go first; the new byte joins the queue.
						line_byte_d = tx_rd_q;
						tx_rp_d = tx_wrap(tx_rp_q);
						tx_we = 1'b1;
						tx_wp_d = tx_wrap(tx_wp_q);
					end
					line_valid_d = 1'b1;
					tx_busy_d = 1'b1;
				end else if (tx_wrap(tx_wp_q) == tx_rp_q) begin
					status_d = ST_TX_FULL;
				end else begin
					tx_we = 1'b1;
					tx_wp_d = tx_wrap(tx_wp_q);
				end
			end
			REQ_TX_DONE: begin
				if (tx_wp_q != tx_rp_q) begin
					line_byte_d = tx_rd_q;
					line_valid_d = 1'b1;
					tx_rp_d = tx_wrap(tx_rp_q);
					tx_busy_d = 1'b1;
				end else begin
					tx_busy_d = 1'b0;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_comb begin
		if (tx_wp_d >= tx_rp_d) begin
			tx_cnt = {1'b0, tx_wp_d} - {1'b0, tx_rp_d};
		end else begin
			tx_cnt = {1'b0, tx_wp_d} + (TX_AW + 1)'(TX_DEPTH) - {1'b0, tx_rp_d};
		end
		tx_room = (TX_AW + 1)'(TX_DEPTH) - tx_cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_wp_q <= '0;
			rx_rp_q <= '0;
			tx_wp_q <= '0;
			tx_rp_q <= '0;
			tx_busy_q <= 1'b0;
		end else if (cmd.execute) begin
			rx_wp_q <= rx_wp_d;
			rx_rp_q <= rx_rp_d;
			tx_wp_q <= tx_wp_d;
			tx_rp_q <= tx_rp_d;
			tx_busy_q <= tx_busy_d;
		end
	end

	// The stores are read at the read pointers when the item is taken in.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_s1 <= req_t'(req_type);
			data_s1 <= data_byte;
			rx_rd_q <= rx_mem[rx_rp_q];
			tx_rd_q <= tx_mem[tx_rp_q];
		end
		if (cmd.execute && rx_we) begin
			rx_mem[rx_wp_q] <= data_s1;
		end
		if (cmd.execute && tx_we) begin
			tx_mem[tx_wp_q] <= data_s1;
		end
		if (cmd.execute) begin
			line_byte_q <= line_byte_d;
			line_valid_q <= line_valid_d;
			host_byte_q <= host_byte_d;
			host_valid_q <= host_valid_d;
			status_q <= status_d;
			tx_free_q <= FREE_W'(tx_room);
		end
	end

	assign line_byte = line_byte_q;
	assign line_valid = line_valid_q;
	assign host_byte = host_byte_q;
	assign host_valid = host_valid_q;
	assign status = status_q;
	assign tx_free = tx_free_q;

endmodule

[rtl/uart_rx_tx_ring_buffers.sv]
// Receive and transmit byte rings for one UART port.
// Input channel (in_valid/in_stall) carries req_type and data_byte: a byte from
// the line, a host get, a host put, or a transmitter-done event. Each transfer
// gives exactly one result on the output channel (out_valid/out_stall) with
// line_byte/line_valid (byte handed to the transmitter), host_byte/host_valid
// (oldest received byte), status and tx_free (free transmit slots).
// After the input transfer the controller passes through its execute state
// to its output state, where out_valid rises and the result can be taken. The
// stores are single-port memories read at the item's transfer edge and written
// in the following cycle. One item is worked on at a time: no new item is taken
// until the result of the last one has left.
// While out_valid is stalled the result holds and in_stall stays high; the next
// input transfer can happen in the cycle after the result is taken.
// Reset clears all four ring pointers and marks the transmitter idle. Store
// contents are not cleared; only entries already written are ever returned.
module uart_rx_tx_ring_buffers import urtb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        req_type,
	input  logic [7:0]        data_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        line_byte,
	output logic              line_valid,
	output logic [7:0]        host_byte,
	output logic              host_valid,
	output logic [1:0]        status,
	output logic [FREE_W-1:0] tx_free
);

	cmd_t cmd;

	urtb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	urtb_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.req_type   (req_type),
		.data_byte  (data_byte),
		.line_byte  (line_byte),
		.line_valid (line_valid),
		.host_byte  (host_byte),
		.host_valid (host_valid),
		.status     (status),
		.tx_free    (tx_free)
	);

	// A returned host byte always comes with an ok status.
	a_host_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && host_valid |-> status == ST_OK)
		else $error("host byte returned with a non-ok status");

	// No single item both returns a host byte and sends a line byte.
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(line_valid && host_valid))
		else $error("line and host bytes in the same result");

	// After an input transfer the block takes nothing until its result leaves.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !out_valid)
		else $error("second item taken while one is in flight");

endmodule
